// ----- rtl/core/lenient_utf8_decoder_core_defines.svh -----
// Assertion macros shared by the checker of the lenient UTF-8 decoder core.
// No dependencies; include by bare file name.
`ifndef LENIENT_UTF8_DECODER_CORE_DEFINES_SVH
`define LENIENT_UTF8_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LUD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lud assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define LUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lud assertion failed");

`endif

// ----- rtl/core/lud_pkg.sv -----
// Shared types, constants and lead-byte decode for the lenient UTF-8 decoder.
// No dependencies.
package lud_pkg;

    localparam int unsigned CP_W      = 21;  // code point width
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MAX_RES   = 4;   // code points one byte can cause
    localparam int unsigned CNT_W     = 3;   // holds 0..MAX_RES
    localparam int unsigned HELD_D    = 3;   // held sequence bytes
    localparam int unsigned OUT_DATA_W = 24; // code point padded to bytes

    // Lead byte kinds
    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } t_lead;

    // One byte's worth of results, travelling from front to back
    typedef struct packed {
        logic [MAX_RES-1:0][CP_W-1:0] cp;
        logic [CNT_W-1:0]             count;
        logic                         eot;
    } t_packet;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Classify a byte seen as the start of a sequence
    function automatic t_lead lead_class(input logic [BYTE_W-1:0] b);
        t_lead k;
        unique case (b) inside
            8'b0???????: k = LEAD_ASCII;
            8'b110?????: k = LEAD_TWO;
            8'b1110????: k = LEAD_THREE;
            8'b11110???: k = LEAD_FOUR;
            default:     k = LEAD_BAD;
        endcase
        return k;
    endfunction

    // Payload bits carried by a multi-byte lead
    function automatic logic [CP_W-1:0] lead_payload(input logic [BYTE_W-1:0] b);
        logic [CP_W-1:0] p;
        unique case (lead_class(b))
            LEAD_TWO:   p = CP_W'(b & 8'h1F);
            LEAD_THREE: p = CP_W'(b & 8'h0F);
            LEAD_FOUR:  p = CP_W'(b & 8'h07);
            default:    p = '0;
        endcase
        return p;
    endfunction

    // Continuation bytes a lead asks for; zero for single bytes
    function automatic logic [1:0] lead_need(input logic [BYTE_W-1:0] b);
        logic [1:0] n;
        unique case (lead_class(b))
            LEAD_TWO:   n = 2'd1;
            LEAD_THREE: n = 2'd2;
            LEAD_FOUR:  n = 2'd3;
            default:    n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/core/lud_front.sv -----
// Front end: accepts text bytes, tracks the open sequence and builds one
// result packet per byte. Depends on lud_pkg.
module lud_front
    import lud_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_eot,
    output t_packet           o_pkt,
    output logic              o_push
);

    logic [HELD_D-1:0][BYTE_W-1:0] r_held, n_held;
    logic [CP_W-1:0]               r_pv, n_pv;
    logic [1:0]                    r_exp, n_exp;
    logic [1:0]                    r_cnt, n_cnt;

    t_packet          pkt;
    logic             fresh;
    logic             is_cont;
    logic [1:0]       exp_m1;
    logic [CP_W-1:0]  pv_ext;
    t_lead            kind;

    assign is_cont = (i_byte[7:6] == 2'b10);
    assign exp_m1  = r_exp - 2'd1;
    assign pv_ext  = {r_pv[CP_W-7:0], i_byte[5:0]};
    assign kind    = lead_class(i_byte);

    // Decide the results and the next sequence state for the offered byte
    always_comb begin
        n_held    = r_held;
        n_pv      = r_pv;
        n_exp     = r_exp;
        n_cnt     = r_cnt;
        pkt.cp    = '0;
        pkt.count = '0;
        pkt.eot   = i_eot;
        fresh     = 1'b0;

        if (r_exp != 2'd0) begin
            if (is_cont) begin
                if (exp_m1 == 2'd0) begin
                    // sequence complete
                    pkt.cp[0] = pv_ext;
                    pkt.count = CNT_W'(1);
                    n_held    = '0;
                    n_pv      = '0;
                    n_exp     = '0;
                    n_cnt     = '0;
                end else begin
                    n_held[r_cnt] = i_byte;
                    n_cnt         = r_cnt + 2'd1;
                    n_pv          = pv_ext;
                    n_exp         = exp_m1;
                    if (i_eot) begin
                        // text ends mid-sequence: pass held bytes and this one raw
                        for (int k = 0; k < HELD_D; k++) begin
                            if (k < int'(r_cnt)) begin
                                pkt.cp[pkt.count[1:0]] = CP_W'(r_held[k]);
                                pkt.count = pkt.count + CNT_W'(1);
                            end
                        end
                        pkt.cp[pkt.count[1:0]] = CP_W'(i_byte);
                        pkt.count = pkt.count + CNT_W'(1);
                    end
                end
            end else begin
                // broken sequence: pass held bytes raw, then restart on this byte
                for (int k = 0; k < HELD_D; k++) begin
                    if (k < int'(r_cnt)) begin
                        pkt.cp[pkt.count[1:0]] = CP_W'(r_held[k]);
                        pkt.count = pkt.count + CNT_W'(1);
                    end
                end
                n_held = '0;
                n_pv   = '0;
                n_exp  = '0;
                n_cnt  = '0;
                fresh  = 1'b1;
            end
        end else begin
            fresh = 1'b1;
        end

        // Treat the byte as a lead
        if (fresh) begin
            if (kind == LEAD_ASCII || kind == LEAD_BAD || i_eot) begin
                pkt.cp[pkt.count[1:0]] = CP_W'(i_byte);
                pkt.count = pkt.count + CNT_W'(1);
            end else begin
                n_held[0] = i_byte;
                n_cnt     = 2'd1;
                n_pv      = lead_payload(i_byte);
                n_exp     = lead_need(i_byte);
            end
        end

        // End of text returns the sequence state to idle
        if (i_eot) begin
            n_held = '0;
            n_pv   = '0;
            n_exp  = '0;
            n_cnt  = '0;
        end
    end

    // Advance sequence state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pv   <= '0;
            r_exp  <= '0;
            r_cnt  <= '0;
        end else if (i_accept) begin
            r_held <= n_held;
            r_pv   <= n_pv;
            r_exp  <= n_exp;
            r_cnt  <= n_cnt;
        end
    end

    assign o_pkt  = pkt;
    assign o_push = i_accept && (pkt.count != '0);

endmodule

// ----- rtl/core/lud_queue.sv -----
// Two-entry packet queue between the front and back ends.
// Depends on lud_pkg.
module lud_queue
    import lud_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_packet   i_pkt,
    input  logic      i_pop,
    output t_packet   o_head,
    output t_q_status o_status
);

    t_packet    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    // Store pushed packets
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_pkt;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    assign o_head         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_fill == 2'd2);
    assign o_status.empty = (r_fill == 2'd0);

endmodule

// ----- rtl/core/lud_back.sv -----
// Back end: walks the head packet one code point per beat into the output
// register. Depends on lud_pkg.
module lud_back
    import lud_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_packet         i_head,
    input  t_q_status       i_status,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [CP_W-1:0] o_cp,
    output logic            o_run_last,
    output logic            o_done
);

    logic            r_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_run_last;
    logic            r_done;
    logic [1:0]      r_idx;

    logic load;
    logic last;

    assign load  = !i_status.empty && (!r_valid || i_ready);
    assign last  = ({1'b0, r_idx} == (i_head.count - CNT_W'(1)));
    assign o_pop = load && last;

    // Step through the head packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the output beat
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp       <= i_head.cp[r_idx];
            r_run_last <= last;
            r_done     <= last && i_head.eot;
        end
    end

    assign o_valid    = r_valid;
    assign o_cp       = r_cp;
    assign o_run_last = r_run_last;
    assign o_done     = r_done;

endmodule

// ----- rtl/core/lenient_utf8_decoder_core.sv -----
// Lenient UTF-8 decoder: one text byte in per beat (tlast marks the last byte of
// a text), code points out. A byte that completes a sequence or stands alone
// gives one code point; a broken sequence or a text that ends inside one gives
// the held raw bytes as code points, up to four beats for one input byte. The
// output port issues one code point per cycle unless stalled, and that register
// sets the rate: a byte stream in which each byte yields at most one code point
// flows at one byte per cycle, while a byte yielding several code points takes
// an output beat for each. A two-entry packet queue between front and back
// absorbs these bursts; input beats pass a queue slot, then the output register.
// tuser carries run_last (last code point caused by an input byte); tlast
// carries text_done. Depends on lud_pkg, lud_front, lud_queue and lud_back.
module lenient_utf8_decoder_core
    import lud_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [BYTE_W-1:0]     i_s_axis_tdata,  // [7:0] text_byte
    input  logic                  i_s_axis_tlast,  // end_of_text
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // [20:0] code_point, [23:21] zero
    output logic [0:0]            o_m_axis_tuser,  // [0] run_last
    output logic                  o_m_axis_tlast   // text_done
);

    t_packet         pkt;
    t_packet         head;
    t_q_status       q_status;
    logic            push;
    logic            pop;
    logic            accept;
    logic [CP_W-1:0] cp;
    logic            run_last;

    assign o_s_axis_tready = !q_status.full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    lud_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_eot    (i_s_axis_tlast),
        .o_pkt    (pkt),
        .o_push   (push)
    );

    lud_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pkt    (pkt),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    lud_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_status   (q_status),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_cp       (cp),
        .o_run_last (run_last),
        .o_done     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_W-CP_W){1'b0}}, cp};
    assign o_m_axis_tuser = run_last;

endmodule

// ----- rtl/core/lud_checker.sv -----
// Port-level checks for the lenient UTF-8 decoder core, bound to the top level.
// Depends on lud_pkg and lenient_utf8_decoder_core_defines.svh.
`include "lenient_utf8_decoder_core_defines.svh"

module lud_checker
    import lud_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]            o_m_axis_tuser,
    input logic                  o_m_axis_tlast
);

    // A stalled output beat holds
    `LUD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))

    // End of text is always the last beat of its input byte
    `LUD_ASSERT_IMPL(a_done_is_run_last, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tuser[0])

    // Padding above the code point stays zero
    `LUD_ASSERT_IMPL(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[OUT_DATA_W-1:CP_W] == '0)

    // Nothing leaves the block in the cycle after reset releases
    `LUD_ASSERT_IMPL(a_quiet_after_reset, i_clk, i_rst_n, $rose(i_rst_n), !o_m_axis_tvalid)

endmodule

bind lenient_utf8_decoder_core lud_checker u_lud_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
